/* rtl/pcpa_pkg.sv */
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types, constants and helpers of the per-cpu page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpa_pkg;

    localparam int NUM_PAGES   = 32768;
    localparam int NUM_CPUS    = 8;
    localparam int STEAL_LIMIT = 1024;

    localparam int PAGE_W    = 15;
    localparam int CPU_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int FIRST_W   = 15;
    localparam int LIMIT_W   = 16;

    localparam int ADDR_W    = $clog2(NUM_PAGES);
    localparam int LINK_W    = ADDR_W + 1;
    localparam int CPU_IDX_W = $clog2(NUM_CPUS);
    localparam int STEP_W    = $clog2(STEAL_LIMIT + 1);

    localparam logic [LINK_W-1:0] LIST_END = LINK_W'(NUM_PAGES);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STS_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FREED     = 2'd2;
    localparam logic [STATUS_W-1:0] STS_REJECTED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'b1;

    localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET = 16'h8000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_STEAL,
        S_WALK
    } state_t;

    typedef struct packed {
        logic              operation;
        logic [CPU_W-1:0]  requester;
        logic [PAGE_W-1:0] page_in;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0]   page_out;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic [FIRST_W-1:0] first_free_page;
        logic [LIMIT_W-1:0] page_limit;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [LINK_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    function automatic logic is_page(logic [LINK_W-1:0] p);
        return p < LINK_W'(NUM_PAGES);
    endfunction

    // requester index folded into the cpu range
    function automatic logic [CPU_IDX_W-1:0] cpu_of(logic [CPU_W-1:0] r);
        logic [CPU_W+1:0] v;
        v = {2'b00, r};
        for (int i = 0; i < 8; i++)
        begin
            if (v >= (CPU_W+2)'(NUM_CPUS))
            begin
                v = v - (CPU_W+2)'(NUM_CPUS);
            end
        end
        return v[CPU_IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/pcpa_ram.sv */
// ----------------------------------------------------------------------------
// pcpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/pcpa_ctrl.sv */
// ----------------------------------------------------------------------------
// pcpa_ctrl
// List heads, request sequencer and result register of the page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpa_ctrl
    import pcpa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire req_t              in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rsp_t                   out_data,
    input  wire cfg_t              cfg,
    output ram_req_t               ram_req,
    input  wire logic [LINK_W-1:0] ram_rdata
);

    state_t state_reg, state_next;

    logic [LINK_W-1:0]    head_reg  [NUM_CPUS];
    logic [LINK_W-1:0]    head_next [NUM_CPUS];
    logic [CPU_IDX_W-1:0] me_reg, me_next;
    logic [CPU_IDX_W-1:0] victim_reg, victim_next;
    logic [ADDR_W-1:0]    got_reg, got_next;
    logic [ADDR_W-1:0]    tail_reg, tail_next;
    logic [LINK_W-1:0]    first_link_reg, first_link_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_t                 out_data_reg, out_data_next;

    logic                 in_fire;
    logic                 slot_free;
    logic                 rsp_load;
    rsp_t                 rsp;
    logic [CPU_IDX_W-1:0] me_in;
    logic [CPU_IDX_W-1:0] head_addr;
    logic [LINK_W-1:0]    head_rd;
    logic [NUM_CPUS-1:0]  nonempty;
    logic                 found;
    logic [CPU_IDX_W-1:0] victim;
    logic [LINK_W-1:0]    pg_ext;
    logic                 in_range;
    logic [LINK_W-1:0]    link_n;
    logic                 walk_on;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign in_fire   = in_valid && in_ready;
    assign me_in     = cpu_of(in_data.requester);
    assign head_addr = (state_reg == S_IDLE) ? me_in : victim_reg;
    assign head_rd   = head_reg[head_addr];
    assign pg_ext    = {1'b0, in_data.page_in};
    assign in_range  = (in_data.page_in >= cfg.first_free_page)
                    && (pg_ext < cfg.page_limit) && is_page(pg_ext);
    assign link_n    = is_page(ram_rdata) ? ram_rdata : LIST_END;
    assign walk_on   = is_page(ram_rdata) && (step_reg != STEP_W'(STEAL_LIMIT));

    always_comb
    begin
        for (int c = 0; c < NUM_CPUS; c++)
        begin
            nonempty[c] = is_page(head_reg[c]);
        end
    end

    // lowest-index cpu other than the requester that holds pages
    always_comb
    begin
        found  = 1'b0;
        victim = '0;
        for (int c = 0; c < NUM_CPUS; c++)
        begin
            if (!found && (CPU_IDX_W'(c) != me_in) && nonempty[c])
            begin
                found  = 1'b1;
                victim = CPU_IDX_W'(c);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                head_reg[c] <= LIST_END;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                head_reg[c] <= head_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        me_reg         <= me_next;
        victim_reg     <= victim_next;
        got_reg        <= got_next;
        tail_reg       <= tail_next;
        first_link_reg <= first_link_next;
        step_reg       <= step_next;
        out_data_reg   <= out_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        me_next         = me_reg;
        victim_next     = victim_reg;
        got_next        = got_reg;
        tail_next       = tail_reg;
        first_link_next = first_link_reg;
        step_next       = step_reg;
        for (int c = 0; c < NUM_CPUS; c++)
        begin
            head_next[c] = head_reg[c];
        end
        ram_req   = '0;
        rsp_load  = 1'b0;
        rsp       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    me_next = me_in;
                    if (in_data.operation == OP_FREE)
                    begin
                        rsp_load = 1'b1;
                        if (in_range)
                        begin
                            ram_req.we        = 1'b1;
                            ram_req.waddr     = in_data.page_in;
                            ram_req.wdata     = head_rd;
                            head_next[me_in]  = pg_ext;
                            rsp.status        = STS_FREED;
                        end
                        else
                        begin
                            rsp.status = STS_REJECTED;
                        end
                    end
                    else if (is_page(head_rd))
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = head_rd[ADDR_W-1:0];
                        got_next      = head_rd[ADDR_W-1:0];
                        state_next    = S_POP;
                    end
                    else if (found)
                    begin
                        victim_next = victim;
                        state_next  = S_STEAL;
                    end
                    else
                    begin
                        rsp_load   = 1'b1;
                        rsp.status = STS_EMPTY;
                    end
                end
            end
            S_POP:
            begin
                if (slot_free)
                begin
                    head_next[me_reg] = link_n;
                    rsp_load          = 1'b1;
                    rsp.page_out      = got_reg;
                    rsp.status        = STS_ALLOCATED;
                    state_next        = S_IDLE;
                end
            end
            S_STEAL:
            begin
                got_next      = head_rd[ADDR_W-1:0];
                tail_next     = head_rd[ADDR_W-1:0];
                step_next     = '0;
                ram_req.re    = 1'b1;
                ram_req.raddr = head_rd[ADDR_W-1:0];
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                if (walk_on)
                begin
                    if (step_reg == '0)
                    begin
                        first_link_next = ram_rdata;
                    end
                    tail_next     = ram_rdata[ADDR_W-1:0];
                    step_next     = step_reg + STEP_W'(1);
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ram_rdata[ADDR_W-1:0];
                end
                else if (slot_free)
                begin
                    // the run is cut off behind the tail, then its head is popped
                    head_next[victim_reg] = link_n;
                    head_next[me_reg]     = (tail_reg == got_reg) ? LIST_END
                                                                  : first_link_reg;
                    ram_req.we    = 1'b1;
                    ram_req.waddr = tail_reg;
                    ram_req.wdata = LIST_END;
                    rsp_load      = 1'b1;
                    rsp.page_out  = got_reg;
                    rsp.status    = STS_ALLOCATED;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rsp_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = rsp;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
            out_data_next  = out_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> slot_free)
        else $error("result loaded over an unread result");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (step_reg <= STEP_W'(STEAL_LIMIT)))
        else $error("steal walk ran past its limit");

    a_victim_not_self: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_STEAL) || (state_reg == S_WALK)) |-> (victim_reg != me_reg))
        else $error("cpu stealing from its own list");

    a_free_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_data.operation == OP_FREE)) |=> (state_reg == S_IDLE))
        else $error("free request did not complete at once");

    a_ram_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> !ram_req.re)
        else $error("link memory read and written together");

endmodule

`default_nettype wire

/* rtl/per_cpu_page_allocator_with_steal_unit.sv */
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_with_steal_unit
// Per-cpu lifo page allocator with list stealing, linked through a link memory.
// ----------------------------------------------------------------------------
// A free request completes in the cycle it is accepted. An allocate request
// served from the requester's own list reads the link of the head page from
// the link memory, then updates the head and presents the page once the
// result register is free. A stealing allocate walks the victim's list, one
// link read per step, over at most the steal limit of pages beyond its head,
// then moves the run to the requester and presents the victim's head page
// once the result register is free. Requests are taken one at a time and a
// new request is accepted as soon as the block is idle and the result register
// is free or being emptied. The link memory needs no clearing after reset.
`default_nettype none

module per_cpu_page_allocator_with_steal_unit
    import pcpa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire req_t                 in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rsp_t                      out_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t              cfg_reg, cfg_next;
    ram_req_t          ram_req;
    logic [LINK_W-1:0] ram_rdata;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FIRST_FREE: cfg_next.first_free_page = cfg_wdata[FIRST_W-1:0];
                CFG_PAGE_LIMIT: cfg_next.page_limit      = cfg_wdata[LIMIT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_free_page <= '0;
            cfg_reg.page_limit      <= PAGE_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pcpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    pcpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg       (cfg_reg),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
